### hdl/gpc_pkg.sv
// Package for the gradient palette color unit: widths, constants, register
// index codes, item kinds, the queue item struct and the segment tables.
// Used by gpc_front, gpc_queue, gpc_back and gradient_palette_color_unit.
`timescale 1ns / 1ps
`default_nettype none

package gpc_pkg;

  // Palette geometry (the index port width follows from it)
  localparam int unsigned PalEntries  = 64;
  localparam int unsigned IndexW      = $clog2(PalEntries + 1);
  localparam int unsigned LenW        = IndexW;

  // Stop registers
  localparam int unsigned NumStopRegs     = 6;
  localparam int unsigned MaxStopsDefault = 6;
  localparam int unsigned StopCountW      = 3;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Color formats
  localparam int unsigned ChanW = 8;
  localparam int unsigned RgbW  = 3 * ChanW;
  localparam int unsigned ArgbW = 32;
  localparam logic [ChanW-1:0] AlphaOpaque = 8'hFF;
  localparam logic [RgbW-1:0]  WhiteRgb    = 24'hFFFFFF;
  localparam logic [RgbW-1:0]  BlackRgb    = 24'h000000;

  // Blend datapath: num = s*(L-j) + e*j, quotient = (num * recip) >> RecipShift.
  // With num < 2^NumW and L <= 2^LenW the reciprocal product is exact.
  localparam int unsigned NumW       = ChanW + LenW;
  localparam int unsigned RecipShift = NumW + LenW;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned ProdW      = NumW + RecipW;

  // Mono mode half length and its reciprocal
  localparam int unsigned MonoHalf  = PalEntries / 2;
  localparam int unsigned MonoRecip = ((2 ** RecipShift) + MonoHalf - 1) / MonoHalf;

  // Segment lengths for 1..5 segments (minimum of one)
  localparam int unsigned NumSegCodes = NumStopRegs - 1;
  localparam int unsigned SegSelW     = $clog2(NumSegCodes);
  localparam int unsigned SegLen [NumSegCodes] = '{
    ((PalEntries / 1) == 0) ? 1 : (PalEntries / 1),
    ((PalEntries / 2) == 0) ? 1 : (PalEntries / 2),
    ((PalEntries / 3) == 0) ? 1 : (PalEntries / 3),
    ((PalEntries / 4) == 0) ? 1 : (PalEntries / 4),
    ((PalEntries / 5) == 0) ? 1 : (PalEntries / 5)
  };
  localparam int unsigned SegRecip [NumSegCodes] = '{
    ((2 ** RecipShift) + SegLen[0] - 1) / SegLen[0],
    ((2 ** RecipShift) + SegLen[1] - 1) / SegLen[1],
    ((2 ** RecipShift) + SegLen[2] - 1) / SegLen[2],
    ((2 ** RecipShift) + SegLen[3] - 1) / SegLen[3],
    ((2 ** RecipShift) + SegLen[4] - 1) / SegLen[4]
  };

  // Queue between front and back
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE       = 3'd0,
    CFG_STOP_COUNT = 3'd1,
    CFG_STOP0      = 3'd2,
    CFG_STOP1      = 3'd3,
    CFG_STOP2      = 3'd4,
    CFG_STOP3      = 3'd5,
    CFG_STOP4      = 3'd6,
    CFG_STOP5      = 3'd7
  } gpc_cfg_idx_e;

  typedef enum logic {
    MODE_MULTI = 1'b0,
    MODE_MONO  = 1'b1
  } gpc_mode_e;

  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,  // index at or past the end
    KIND_SOLID = 2'd1,  // fixed opaque color, no blend
    KIND_BLEND = 2'd2   // interpolate start to end
  } gpc_kind_e;

  typedef struct packed {
    gpc_kind_e         kind;
    logic [RgbW-1:0]   from_rgb;  // also the solid color
    logic [RgbW-1:0]   end_rgb;
    logic [LenW-1:0]   offset;
    logic [LenW-1:0]   seg_len;
    logic [RecipW-1:0] recip;
  } gpc_item_t;

endpackage : gpc_pkg

`default_nettype wire

### hdl/gpc_front.sv
// Front end: configuration registers, index classification and the front
// register that feeds the queue. Depends on gpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpc_front
  import gpc_pkg::*;
#(
  parameter int unsigned MAX_STOPS = MaxStopsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [IndexW-1:0]   palette_index_i,
  input  logic                q_full_i,
  output logic                push_o,
  output gpc_item_t           item_o
);

  localparam int unsigned StopIdxW = (MAX_STOPS > 2) ? $clog2(MAX_STOPS) : 1;
  localparam int unsigned BaseW    = LenW + StopIdxW;

  gpc_mode_e              mode_q;
  logic [StopCountW-1:0]  stop_count_q;
  logic [RgbW-1:0]        stop_q [MAX_STOPS];

  logic                   f_valid_q, f_valid_d;
  gpc_item_t              f_item_q;
  gpc_item_t              item_d;
  logic                   accept;

  logic [CfgIdxW-1:0]     stop_wr_idx;
  logic [StopCountW-1:0]  n_stops;
  logic [StopCountW-1:0]  segs;
  logic [StopCountW-1:0]  seg_sel_full;
  logic [SegSelW-1:0]     seg_sel;
  logic [LenW-1:0]        seg_len;
  logic [RecipW-1:0]      seg_recip;
  logic [StopIdxW:0]      seg_x;
  logic [BaseW-1:0]       seg_base;
  logic [RgbW-1:0]        stop_a, stop_b, stop_last;

  // Configuration writes
  assign stop_wr_idx = cfg_index_i - CfgIdxW'(CFG_STOP0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_MULTI;
      stop_count_q <= StopCountW'(2);
      for (int i = 0; i < MAX_STOPS; i++) begin
        stop_q[i] <= (i == 1) ? WhiteRgb : BlackRgb;
      end
    end else if (cfg_we_i) begin
      unique case (gpc_cfg_idx_e'(cfg_index_i)) inside
        CFG_MODE:       mode_q       <= gpc_mode_e'(cfg_wdata_i[0]);
        CFG_STOP_COUNT: stop_count_q <= cfg_wdata_i[StopCountW-1:0];
        [CFG_STOP0:CFG_STOP5]: begin
          for (int i = 0; i < MAX_STOPS; i++) begin
            if (stop_wr_idx == CfgIdxW'(i)) stop_q[i] <= cfg_wdata_i[RgbW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Segment geometry from the clamped stop count
  always_comb begin
    if (stop_count_q < StopCountW'(2)) begin
      n_stops = StopCountW'(2);
    end else if (stop_count_q > StopCountW'(MAX_STOPS)) begin
      n_stops = StopCountW'(MAX_STOPS);
    end else begin
      n_stops = stop_count_q;
    end
    segs         = n_stops - StopCountW'(1);
    seg_sel_full = segs - StopCountW'(1);
    seg_sel      = seg_sel_full[SegSelW-1:0];
    seg_len      = LenW'(SegLen[seg_sel]);
    seg_recip    = RecipW'(SegRecip[seg_sel]);
  end

  // Segment of the index: count the boundaries at or below it
  always_comb begin
    seg_x    = '0;
    seg_base = '0;
    for (int i = 1; i < MAX_STOPS; i++) begin
      if (BaseW'(palette_index_i) >= BaseW'(i) * BaseW'(seg_len)) begin
        seg_x    = (StopIdxW + 1)'(i);
        seg_base = BaseW'(i) * BaseW'(seg_len);
      end
    end
  end

  // Stop colors at the segment ends and at the last stop
  always_comb begin
    stop_a    = BlackRgb;
    stop_b    = BlackRgb;
    stop_last = BlackRgb;
    for (int i = 0; i < MAX_STOPS; i++) begin
      if (seg_x == (StopIdxW + 1)'(i))                          stop_a    = stop_q[i];
      if (seg_x + (StopIdxW + 1)'(1) == (StopIdxW + 1)'(i))     stop_b    = stop_q[i];
      if (segs == StopCountW'(i))                               stop_last = stop_q[i];
    end
  end

  // Classification
  always_comb begin
    item_d          = '0;
    item_d.kind     = KIND_ZERO;
    item_d.from_rgb = BlackRgb;
    item_d.end_rgb  = BlackRgb;
    if (palette_index_i >= IndexW'(PalEntries)) begin
      item_d.kind = KIND_ZERO;
    end else if (mode_q == MODE_MONO) begin
      item_d.seg_len = LenW'(MonoHalf);
      item_d.recip   = RecipW'(MonoRecip);
      if (palette_index_i < IndexW'(MonoHalf)) begin
        item_d.kind     = KIND_BLEND;
        item_d.from_rgb = BlackRgb;
        item_d.end_rgb  = stop_q[0];
        item_d.offset   = LenW'(palette_index_i);
      end else if (palette_index_i < IndexW'(2 * MonoHalf)) begin
        item_d.kind     = KIND_BLEND;
        item_d.from_rgb = stop_q[0];
        item_d.end_rgb  = WhiteRgb;
        item_d.offset   = LenW'(palette_index_i - IndexW'(MonoHalf));
      end else begin
        item_d.kind     = KIND_SOLID;
        item_d.from_rgb = WhiteRgb;
      end
    end else begin
      item_d.seg_len = seg_len;
      item_d.recip   = seg_recip;
      if ((StopCountW + 1)'(seg_x) >= (StopCountW + 1)'(segs)) begin
        item_d.kind     = KIND_SOLID;
        item_d.from_rgb = stop_last;
      end else begin
        item_d.kind     = KIND_BLEND;
        item_d.from_rgb = stop_a;
        item_d.end_rgb  = stop_b;
        item_d.offset   = LenW'(BaseW'(palette_index_i) - seg_base);
      end
    end
  end

  // Front register
  assign in_stall_o = f_valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = f_valid_q && !q_full_i;
  assign item_o     = f_item_q;

  always_comb begin
    f_valid_d = f_valid_q;
    if (accept) begin
      f_valid_d = 1'b1;
    end else if (push_o) begin
      f_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) f_item_q <= item_d;
  end

endmodule : gpc_front

`default_nettype wire

### hdl/gpc_queue.sv
// Short FIFO of classified items between the front and the back.
// Depends on gpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpc_queue
  import gpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  gpc_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output gpc_item_t item_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  gpc_item_t       mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  // Occupancy never runs past the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(QueueDepth))
    else $error("queue count past depth");
  // The front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  // The back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule : gpc_queue

`default_nettype wire

### hdl/gpc_back.sv
// Back end: three-stage blend pipeline (weighted sum, reciprocal multiply,
// ARGB output register). Depends on gpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpc_back
  import gpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  gpc_item_t        item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ArgbW-1:0] argb_color_o
);

  // Stage 1: per-channel weighted sums
  logic              v1_q;
  gpc_kind_e         kind1_q;
  logic [RgbW-1:0]   rgb1_q;
  logic [NumW-1:0]   num1_q [3];
  logic [RecipW-1:0] recip1_q;
  logic [NumW-1:0]   num_d  [3];

  // Stage 2: reciprocal products
  logic              v2_q;
  gpc_kind_e         kind2_q;
  logic [RgbW-1:0]   rgb2_q;
  logic [ProdW-1:0]  prod2_q [3];

  // Stage 3: output register
  logic              v3_q;
  gpc_kind_e         kind3_q;
  logic [ArgbW-1:0]  argb3_q;
  logic [ArgbW-1:0]  argb_d;

  logic              r1, r2, r3;

  assign r3    = !v3_q || !out_stall_i;
  assign r2    = !v2_q || r3;
  assign r1    = !v1_q || r2;
  assign pop_o = !q_empty_i && r1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_d[c] = NumW'(item_i.from_rgb[c*ChanW +: ChanW])
                   * NumW'(item_i.seg_len - item_i.offset)
               + NumW'(item_i.end_rgb[c*ChanW +: ChanW]) * NumW'(item_i.offset);
    end
  end

  always_comb begin
    unique case (kind2_q)
      KIND_SOLID: argb_d = {AlphaOpaque, rgb2_q};
      KIND_BLEND: argb_d = {AlphaOpaque,
                            prod2_q[2][RecipShift +: ChanW],
                            prod2_q[1][RecipShift +: ChanW],
                            prod2_q[0][RecipShift +: ChanW]};
      default:    argb_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= pop_o;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind1_q  <= item_i.kind;
      rgb1_q   <= item_i.from_rgb;
      recip1_q <= item_i.recip;
      for (int c = 0; c < 3; c++) num1_q[c] <= num_d[c];
    end
    if (v1_q && r2) begin
      kind2_q <= kind1_q;
      rgb2_q  <= rgb1_q;
      for (int c = 0; c < 3; c++) prod2_q[c] <= ProdW'(num1_q[c]) * ProdW'(recip1_q);
    end
    if (v2_q && r3) begin
      kind3_q <= kind2_q;
      argb3_q <= argb_d;
    end
  end

  assign out_valid_o  = v3_q;
  assign argb_color_o = argb3_q;

  // A transaction popped from the queue lands in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_o |=> v1_q)
    else $error("popped item lost before stage 1");
  // Stage 2 holds its products while stage 3 is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   v2_q && !r3 |=> v2_q && $stable(prod2_q[0]) && $stable(kind2_q))
    else $error("stage 2 changed under stall");
  // Every non-zero result is opaque
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   v3_q && kind3_q != KIND_ZERO |-> argb3_q[ArgbW-1 -: ChanW] == AlphaOpaque)
    else $error("non-zero color without opaque alpha");

endmodule : gpc_back

`default_nettype wire

### hdl/gradient_palette_color_unit.sv
// Top level of the gradient palette color unit: front classifier, item
// queue and blend back end. Depends on gpc_pkg, gpc_front, gpc_queue, gpc_back.
`timescale 1ns / 1ps
`default_nettype none

// Maps a palette index to the opaque ARGB color of a linear RGB gradient
// palette of 64 entries. Multi-stop mode splits the range into stop_count-1
// equal segments (length 64/(stops-1)) and blends each channel between
// neighboring stops, truncating; indices past the last segment give the last
// stop. Mono mode runs black to stop_color_0 over the first half and on to
// white over the second. Index 64 and above gives 0. Rate: one transaction
// per cycle on both channels while no stall holds the flow; with no stall an
// accepted index passes the front register (loaded at the accepting edge),
// a queue slot, the sum stage, the reciprocal multiply stage and the output
// register before out_valid_o rises. The division by the segment length is a
// multiply by a stored reciprocal, so no iterative unit limits throughput.
// The queue lets the front keep accepting while the output is stalled,
// up to its depth plus the front register and the three back stages.
// Write configuration registers only while the unit is empty; register
// index 0 is mode, 1 stop_count, 2..7 stop_color_0..5 (0xRRGGBB).

module gradient_palette_color_unit
  import gpc_pkg::*;
#(
  parameter int unsigned MAX_STOPS = MaxStopsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // index channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [IndexW-1:0]   palette_index_i,
  // color channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ArgbW-1:0]    argb_color_o
);

  logic      push, q_full, q_empty, pop;
  gpc_item_t front_item, queue_item;

  // Classifies each index into zero, solid or blend with its end colors
  gpc_front #(
    .MAX_STOPS(MAX_STOPS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .palette_index_i (palette_index_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .item_o          (front_item)
  );

  // Decouples front stall from output stall
  gpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (queue_item)
  );

  // Blend arithmetic and output register
  gpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .item_i       (queue_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .argb_color_o (argb_color_o)
  );

endmodule : gradient_palette_color_unit

`default_nettype wire
